// File: rtl/bop_pkg.sv
// Shared types and constants of the best-offset prefetcher.
// Transaction structs, register indexes, field widths and reset values.
// No dependencies; the top level imports this package, bop_ram does not.
package bop_pkg;

  localparam int LINE_W     = 58;
  localparam int SET_W      = 9;
  localparam int WAY_W      = 3;
  localparam int MSHR_W     = 6;
  localparam int OFS_W      = 6;
  localparam int SCORE_W    = 8;
  localparam int ROUND_W    = 8;
  localparam int TAG_W      = 12;
  localparam int HASH_W     = 8;
  localparam int HASH_RANGE = 1 << HASH_W;
  localparam int PAGE_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [SCORE_W-1:0] SCORE_SAT = {SCORE_W{1'b1}};

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MSHR_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_SCORE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MAX      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MAX      = 2'd3;

  localparam logic [MSHR_W-1:0]  MSHR_THRESHOLD_RST = 6'd8;
  localparam logic [SCORE_W-1:0] BAD_SCORE_RST      = 8'd1;
  localparam logic [SCORE_W-1:0] SCORE_MAX_RST      = 8'd31;
  localparam logic [ROUND_W-1:0] ROUND_MAX_RST      = 8'd100;

  typedef struct packed {
    logic              cmd;
    logic [LINE_W-1:0] line_addr;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic              is_hit;
    logic              fill_prefetch;
    logic [MSHR_W-1:0] mshr_count;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] prefetch_line;
    logic              fill_llc;
  } out_item_t;

endpackage

// File: rtl/bop_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for every memory of the prefetcher; no dependencies.
module bop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/best_offset_prefetcher_top.sv
// Best-offset L2 prefetcher, top level: three pipeline registers and the memories.
// Depends on bop_pkg and bop_ram.
//
// The block takes one transaction per clock (cache access or cache fill) when
// in_stall is low and returns at most one prefetch for it, through the stage-1,
// stage-2 and output registers. The rate of one transaction per cycle is set
// by the single read-modify-write per cycle on the recent-requests tag memory
// and on the offset score memory, with write-to-read forwarding between
// neighboring transactions. After reset a sweep clears all SETS*WAYS entries
// (4096 by default) of the prefetched-mark memory, one entry per cycle, while
// in_stall stays high; configuration writes are taken during the sweep.
module best_offset_prefetcher_top #(
  parameter int SETS          = 512,
  parameter int WAYS          = 8,
  parameter int OFFSET_COUNT  = 62,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bop_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bop_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [bop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bop_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bop_pkg::*;

  localparam int MARK_DEPTH = SETS * WAYS;
  localparam int MARK_AW    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int TAG_DEPTH  = (TABLE_ENTRIES < HASH_RANGE) ? TABLE_ENTRIES : HASH_RANGE;
  localparam int TAG_AW     = $clog2(TAG_DEPTH);
  localparam int SCORE_AW   = (OFFSET_COUNT > 1) ? $clog2(OFFSET_COUNT) : 1;

  localparam logic [OFS_W-1:0]   LAST_PHASE = OFS_W'(OFFSET_COUNT - 1);
  localparam logic [OFS_W-1:0]   PHASE_END  = OFS_W'(OFFSET_COUNT);
  localparam logic [MARK_AW-1:0] MARK_LAST  = MARK_AW'(MARK_DEPTH - 1);

  // Configuration registers.
  logic [MSHR_W-1:0]  mshr_threshold_r;
  logic [SCORE_W-1:0] bad_score_r;
  logic [SCORE_W-1:0] score_max_r;
  logic [ROUND_W-1:0] round_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mshr_threshold_r <= MSHR_THRESHOLD_RST;
      bad_score_r      <= BAD_SCORE_RST;
      score_max_r      <= SCORE_MAX_RST;
      round_max_r      <= ROUND_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MSHR_THRESHOLD: mshr_threshold_r <= cfg_data[MSHR_W-1:0];
        CFG_BAD_SCORE:      bad_score_r      <= cfg_data[SCORE_W-1:0];
        CFG_SCORE_MAX:      score_max_r      <= cfg_data[SCORE_W-1:0];
        CFG_ROUND_MAX:      round_max_r      <= cfg_data[ROUND_W-1:0];
      endcase
    end
  end

  // Hash index reduction to the tag memory depth, as a constant table.
  logic [TAG_AW-1:0] hash_map [HASH_RANGE];

  for (genvar g = 0; g < HASH_RANGE; g++) begin : g_hash_map
    assign hash_map[g] = TAG_AW'(g % TAG_DEPTH);
  end

  // Pipeline flow control.
  logic out_valid_r;
  logic s1_v_r;
  logic s2_v_r;
  logic clr_r;
  logic out_ready;
  logic s2_free;
  logic s2_go;
  logic s1_free;
  logic s1_go;
  logic in_accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_go     = s2_v_r && out_ready;
  assign s2_free   = !s2_v_r || out_ready;
  assign s1_go     = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_stall  = !rst_n || clr_r || !s1_free;
  assign in_accept = in_valid && !in_stall;

  // Location of the line in the prefetched-mark memory.
  logic               in_loc_ok;
  logic [MARK_AW-1:0] in_loc;

  assign in_loc_ok = (32'(in_data.set_index) < 32'(SETS)) &&
                     (32'(in_data.way_index) < 32'(WAYS));
  assign in_loc    = in_loc_ok ?
                     MARK_AW'(32'(in_data.set_index) * 32'(WAYS) + 32'(in_data.way_index)) :
                     '0;

  // Mark memory clearing sweep after reset.
  logic [MARK_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == MARK_LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Stage 1: mark lookup, qualification and test phase.
  in_item_t           s1_item_r;
  logic               s1_loc_ok_r;
  logic [MARK_AW-1:0] s1_loc_r;
  logic               mfwd_hit_r;
  logic               mfwd_data_r;
  logic               mark_q;
  logic [OFS_W-1:0]   test_phase_r;
  logic [OFS_W-1:0]   test_phase_nxt;

  logic               s1_access;
  logic               s1_mark;
  logic               s1_was_pf;
  logic               s1_qual;
  logic               s1_mwe;
  logic               s1_mdata;
  logic [OFS_W-1:0]   s1_off;
  logic               s1_test_ok;
  logic [PAGE_W-1:0]  s1_tlow;
  logic [HASH_W-1:0]  s1_hash;
  logic [TAG_AW-1:0]  s1_tidx;
  logic [SCORE_AW-1:0] s1_phase;
  logic               s1_wrap;

  logic               mark_we;
  logic [MARK_AW-1:0] mark_waddr;
  logic               mark_wdata;

  assign s1_access  = s1_item_r.cmd == CMD_ACCESS;
  assign s1_mark    = mfwd_hit_r ? mfwd_data_r : mark_q;
  assign s1_was_pf  = s1_item_r.is_hit && s1_loc_ok_r && s1_mark;
  assign s1_qual    = s1_access && (!s1_item_r.is_hit || s1_was_pf);
  assign s1_mwe     = s1_go && s1_loc_ok_r && (!s1_access || s1_item_r.is_hit);
  assign s1_mdata   = !s1_access && s1_item_r.fill_prefetch;

  assign s1_off     = test_phase_r + 1'b1;
  assign s1_test_ok = s1_item_r.line_addr[PAGE_W-1:0] >= s1_off;
  assign s1_tlow    = s1_item_r.line_addr[PAGE_W-1:0] - s1_off;
  assign s1_hash    = {s1_item_r.line_addr[HASH_W-1:PAGE_W], s1_tlow} ^
                      s1_item_r.line_addr[2*HASH_W-1:HASH_W];
  assign s1_tidx    = hash_map[s1_hash];
  assign s1_phase   = test_phase_r[SCORE_AW-1:0];
  assign s1_wrap    = test_phase_r == LAST_PHASE;

  assign mark_we    = clr_r || s1_mwe;
  assign mark_waddr = clr_r ? clr_cnt_r : s1_loc_r;
  assign mark_wdata = clr_r ? 1'b0 : s1_mdata;

  always_comb begin
    test_phase_nxt = test_phase_r;
    if (s1_go && s1_qual) begin
      test_phase_nxt = s1_wrap ? '0 : s1_off;
    end
  end

  bop_ram #(
    .WIDTH (1),
    .DEPTH (MARK_DEPTH)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (mark_we),
    .wr_addr (mark_waddr),
    .wr_data (mark_wdata),
    .rd_en   (s1_free),
    .rd_addr (in_loc),
    .rd_data (mark_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      test_phase_r <= '0;
    end else begin
      test_phase_r <= test_phase_nxt;
      if (s1_free) begin
        s1_v_r <= in_accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_item_r   <= in_data;
      s1_loc_ok_r <= in_loc_ok;
      s1_loc_r    <= in_loc;
      mfwd_hit_r  <= s1_mwe && (s1_loc_r == in_loc);
      mfwd_data_r <= s1_mdata;
    end
  end

  // Stage 2: tag match, scoring, learning phase and prefetch generation.
  logic                 s2_cmd_r;
  logic                 s2_qual_r;
  logic [LINE_W-1:0]    s2_line_r;
  logic                 s2_fill_pf_r;
  logic [MSHR_W-1:0]    s2_mshr_r;
  logic                 s2_test_ok_r;
  logic [TAG_AW-1:0]    s2_tidx_r;
  logic [SCORE_AW-1:0]  s2_phase_r;
  logic [OFS_W-1:0]     s2_off_r;
  logic                 s2_wrap_r;
  logic                 tfwd_hit_r;
  logic [TAG_W-1:0]     tfwd_data_r;
  logic                 sfwd_hit_r;
  logic [SCORE_W-1:0]   sfwd_data_r;
  logic [TAG_W-1:0]     tag_q;
  logic [SCORE_W-1:0]   score_q;

  logic [TAG_DEPTH-1:0]    tag_vld_r;
  logic [TAG_DEPTH-1:0]    tag_vld_nxt;
  logic [OFFSET_COUNT-1:0] score_vld_r;
  logic [OFFSET_COUNT-1:0] score_vld_nxt;
  logic [SCORE_W-1:0]      top_score_r;
  logic [SCORE_W-1:0]      top_score_nxt;
  logic [OFS_W-1:0]        top_offset_r;
  logic [OFS_W-1:0]        top_offset_nxt;
  logic [ROUND_W-1:0]      round_count_r;
  logic [ROUND_W-1:0]      round_count_nxt;
  logic [OFS_W-1:0]        active_offset_r;
  logic [OFS_W-1:0]        active_offset_nxt;

  logic [TAG_W-1:0]    s2_tag;
  logic [TAG_W-1:0]    s2_tag_eff;
  logic                s2_match;
  logic [SCORE_W-1:0]  s2_score_eff;
  logic [SCORE_W-1:0]  s2_score_inc;
  logic                s2_upd;
  logic                s2_top_take;
  logic [SCORE_W-1:0]  s2_top_mid;
  logic [OFS_W-1:0]    s2_top_off_mid;
  logic [ROUND_W-1:0]  s2_round_mid;
  logic                s2_phase_end;
  logic [OFS_W-1:0]    s2_act_mid;
  logic [PAGE_W:0]     s2_target_low;
  logic                s2_emit;
  logic                s2_base_ok;
  logic [PAGE_W-1:0]   s2_blow;
  logic [HASH_W-1:0]   s2_fhash;
  logic [TAG_AW-1:0]   s2_fidx;
  logic                tag_we;
  logic                score_we;

  assign s2_tag       = s2_line_r[HASH_W+TAG_W-1:HASH_W];
  assign s2_tag_eff   = tag_vld_r[s2_tidx_r] ? (tfwd_hit_r ? tfwd_data_r : tag_q) : '0;
  assign s2_match     = s2_test_ok_r && (s2_tag_eff == s2_tag);
  assign s2_score_eff = score_vld_r[s2_phase_r] ? (sfwd_hit_r ? sfwd_data_r : score_q) : '0;
  assign s2_score_inc = (s2_score_eff == SCORE_SAT) ? s2_score_eff : s2_score_eff + 1'b1;
  assign s2_upd       = s2_go && s2_qual_r;
  assign s2_top_take  = s2_match && (s2_score_inc >= top_score_r);
  assign s2_top_mid   = s2_top_take ? s2_score_inc : top_score_r;
  assign s2_top_off_mid = s2_top_take ? s2_off_r : top_offset_r;
  assign s2_round_mid = s2_wrap_r ? round_count_r + 1'b1 : round_count_r;
  assign s2_phase_end = s2_wrap_r &&
                        ((s2_top_mid >= score_max_r) || (s2_round_mid >= round_max_r));
  assign s2_act_mid   = !s2_phase_end ? active_offset_r :
                        (s2_top_mid <= bad_score_r) ? '0 : s2_top_off_mid;
  assign s2_target_low = {1'b0, s2_line_r[PAGE_W-1:0]} + {1'b0, s2_act_mid};
  assign s2_emit      = s2_qual_r && (s2_act_mid != '0) && !s2_target_low[PAGE_W];

  assign s2_base_ok   = s2_line_r[PAGE_W-1:0] >= active_offset_r;
  assign s2_blow      = s2_line_r[PAGE_W-1:0] - active_offset_r;
  assign s2_fhash     = {s2_line_r[HASH_W-1:PAGE_W], s2_blow} ^
                        s2_line_r[2*HASH_W-1:HASH_W];
  assign s2_fidx      = hash_map[s2_fhash];
  assign tag_we       = s2_go && (s2_cmd_r == CMD_FILL) &&
                        (s2_fill_pf_r || (active_offset_r == '0)) && s2_base_ok;
  assign score_we     = s2_upd && s2_match;

  always_comb begin
    tag_vld_nxt       = tag_vld_r;
    score_vld_nxt     = score_vld_r;
    top_score_nxt     = top_score_r;
    top_offset_nxt    = top_offset_r;
    round_count_nxt   = round_count_r;
    active_offset_nxt = active_offset_r;
    if (tag_we) begin
      tag_vld_nxt[s2_fidx] = 1'b1;
    end
    if (s2_upd) begin
      top_offset_nxt    = s2_top_off_mid;
      active_offset_nxt = s2_act_mid;
      if (s2_phase_end) begin
        score_vld_nxt   = '0;
        top_score_nxt   = '0;
        round_count_nxt = '0;
      end else begin
        top_score_nxt   = s2_top_mid;
        round_count_nxt = s2_round_mid;
        if (s2_match) begin
          score_vld_nxt[s2_phase_r] = 1'b1;
        end
      end
    end
  end

  bop_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (s2_fidx),
    .wr_data (s2_tag),
    .rd_en   (s2_free),
    .rd_addr (s1_tidx),
    .rd_data (tag_q)
  );

  bop_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (OFFSET_COUNT)
  ) u_score_ram (
    .clk     (clk),
    .wr_en   (score_we),
    .wr_addr (s2_phase_r),
    .wr_data (s2_score_inc),
    .rd_en   (s2_free),
    .rd_addr (s1_phase),
    .rd_data (score_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r          <= 1'b0;
      tag_vld_r       <= '0;
      score_vld_r     <= '0;
      top_score_r     <= '0;
      top_offset_r    <= '0;
      round_count_r   <= '0;
      active_offset_r <= '0;
    end else begin
      tag_vld_r       <= tag_vld_nxt;
      score_vld_r     <= score_vld_nxt;
      top_score_r     <= top_score_nxt;
      top_offset_r    <= top_offset_nxt;
      round_count_r   <= round_count_nxt;
      active_offset_r <= active_offset_nxt;
      if (s2_free) begin
        s2_v_r <= s1_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_cmd_r     <= s1_item_r.cmd;
      s2_qual_r    <= s1_qual;
      s2_line_r    <= s1_item_r.line_addr;
      s2_fill_pf_r <= s1_item_r.fill_prefetch;
      s2_mshr_r    <= s1_item_r.mshr_count;
      s2_test_ok_r <= s1_test_ok;
      s2_tidx_r    <= s1_tidx;
      s2_phase_r   <= s1_phase;
      s2_off_r     <= s1_off;
      s2_wrap_r    <= s1_wrap;
      tfwd_hit_r   <= tag_we && (s2_fidx == s1_tidx);
      tfwd_data_r  <= s2_tag;
      sfwd_hit_r   <= score_we && (s2_phase_r == s1_phase);
      sfwd_data_r  <= s2_score_inc;
    end
  end

  // Output register.
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_go && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data_r.prefetch_line <= {s2_line_r[LINE_W-1:PAGE_W], s2_target_low[PAGE_W-1:0]};
      out_data_r.fill_llc      <= s2_mshr_r >= mshr_threshold_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The active offset only moves at the end of a learning phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (active_offset_r != $past(active_offset_r)))
      |-> $past(s2_upd && s2_phase_end))
    else $error("active offset changed outside a learning phase end");

  // A nonzero best score always comes with the offset that earned it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (top_score_r != '0) |-> (top_offset_r != '0))
    else $error("best score without a best offset");

  // The test phase stays inside the candidate offset list.
  assert property (@(posedge clk) disable iff (!rst_n)
    test_phase_r < PHASE_END)
    else $error("test phase out of range");

  // Every score reads as zero once a learning phase has ended.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n && s2_upd && s2_phase_end) |-> (score_vld_r == '0))
    else $error("scores not cleared at the end of a learning phase");

endmodule
